// File: rtl/core/bdq_pkg.sv
// Shared types and codes for the bounded deque with search.
`default_nettype none

package bdq_pkg;

    localparam logic [2:0] CMD_ADD_LAST  = 3'd0;
    localparam logic [2:0] CMD_ADD_FIRST = 3'd1;
    localparam logic [2:0] CMD_REM_FIRST = 3'd2;
    localparam logic [2:0] CMD_REM_LAST  = 3'd3;
    localparam logic [2:0] CMD_SEARCH    = 3'd4;
    localparam logic [2:0] CMD_REVERSE   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic        [2:0]  cmd;
        logic signed [31:0] item;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [3:0] index;
        logic [4:0] count;
    } res_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;
        logic load;
        logic fetch;
        logic step;
        logic hit;
        logic miss;
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic match;
        logic last;
    } stat_t;

endpackage

`default_nettype wire

// File: rtl/core/bdq_dp.sv
// Datapath: circular entry memory, head pointer, count, direction flag and search scan.
`default_nettype none

module bdq_dp #(
    parameter int DEPTH = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire bdq_pkg::req_t request,
    input  wire bdq_pkg::ctl_t ctl,
    output bdq_pkg::stat_t    stat,
    output bdq_pkg::res_t     result
);
    import bdq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
        return (a == LAST_ADDR) ? '0 : a + AW'(1);
    endfunction

    function automatic logic [AW-1:0] addr_dec(input logic [AW-1:0] a);
        return (a == '0) ? LAST_ADDR : a - AW'(1);
    endfunction

    // The address stays below DEPTH and the count at most DEPTH, so one compare and subtract wraps the sum.
    function automatic logic [AW-1:0] addr_add(input logic [AW-1:0] a,
                                               input logic [CW-1:0] n);
        logic [AW:0] s;
        s = {1'b0, a} + (AW+1)'(n);
        if (s >= (AW+1)'(DEPTH))
        begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [4:0] cnt_field(input logic [CW-1:0] c);
        logic [CW+4:0] w;
        w = {5'b0, c};
        return w[4:0];
    endfunction

    function automatic logic [3:0] idx_field(input logic [AW-1:0] p);
        logic [AW+3:0] w;
        w = {4'b0, p};
        return w[3:0];
    endfunction

    logic signed [31:0] cells_mem [DEPTH];

    logic [AW-1:0]      head_reg, head_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               rev_reg, rev_next;
    logic [AW-1:0]      ptr_reg, ptr_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic signed [31:0] item_reg, item_next;
    logic signed [31:0] rd_data_reg;
    res_t               res_reg, res_next;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      tail;
    logic               low_end;
    logic               is_full;
    logic               is_empty;
    logic [1:0]         st;

    assign tail     = addr_add(head_reg, count_reg - CW'(1));
    assign is_full  = (count_reg == FULL_CNT);
    assign is_empty = (count_reg == '0);
    // The low physical end is the front when the list is not reversed.
    assign low_end  = ((request.cmd == CMD_ADD_FIRST) || (request.cmd == CMD_REM_FIRST))
                      == !rev_reg;

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        rev_next   = rev_reg;
        ptr_next   = ptr_reg;
        pos_next   = pos_reg;
        item_next  = item_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        wr_addr    = low_end ? addr_dec(head_reg) : addr_add(head_reg, count_reg);
        st         = ST_OK;

        if (ctl.exec)
        begin
            unique case (request.cmd)
                CMD_ADD_LAST, CMD_ADD_FIRST:
                begin
                    if (is_full)
                    begin
                        st = ST_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                        if (low_end)
                        begin
                            head_next = addr_dec(head_reg);
                        end
                    end
                end
                CMD_REM_FIRST, CMD_REM_LAST:
                begin
                    if (is_empty)
                    begin
                        st = ST_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                        if (low_end)
                        begin
                            head_next = addr_inc(head_reg);
                        end
                    end
                end
                CMD_REVERSE:
                begin
                    rev_next = !rev_reg;
                end
                default:
                begin
                    st = ST_OK;
                end
            endcase
            res_next.status = st;
            res_next.found  = 1'b0;
            res_next.index  = '0;
            res_next.count  = cnt_field(count_next);
        end

        if (ctl.load)
        begin
            item_next = request.item;
            ptr_next  = rev_reg ? tail : head_reg;
            pos_next  = '0;
        end

        if (ctl.fetch || ctl.step)
        begin
            ptr_next = rev_reg ? addr_dec(ptr_reg) : addr_inc(ptr_reg);
        end

        if (ctl.step)
        begin
            pos_next = pos_reg + AW'(1);
        end

        if (ctl.hit)
        begin
            res_next.status = ST_OK;
            res_next.found  = 1'b1;
            res_next.index  = idx_field(pos_reg);
            res_next.count  = cnt_field(count_reg);
        end

        if (ctl.miss)
        begin
            res_next.status = ST_OK;
            res_next.found  = 1'b0;
            res_next.index  = '0;
            res_next.count  = cnt_field(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            rev_reg   <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            rev_reg   <= rev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        pos_reg  <= pos_next;
        item_reg <= item_next;
        res_reg  <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cells_mem[wr_addr] <= request.item;
        end
        if (ctl.fetch || ctl.step)
        begin
            rd_data_reg <= cells_mem[ptr_reg];
        end
    end

    assign stat.empty = is_empty;
    assign stat.match = (rd_data_reg == item_reg);
    assign stat.last  = (CW'(pos_reg) == count_reg - CW'(1));
    assign result     = res_reg;

endmodule

`default_nettype wire

// File: rtl/core/bdq_ctrl.sv
// Controller state machine: sequences the non-search commands and the search scan.
`default_nettype none

module bdq_ctrl (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire logic [2:0] cmd,
    input  wire bdq_pkg::stat_t stat,
    output bdq_pkg::ctl_t  ctl,
    output logic           busy,
    output logic           done
);
    import bdq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FETCH = 3'b010,
        S_SCAN  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        ctl        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if ((cmd == CMD_SEARCH) && !stat.empty)
                    begin
                        ctl.load   = 1'b1;
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        ctl.exec  = 1'b1;
                        done_next = 1'b1;
                    end
                end
            end
            S_FETCH:
            begin
                ctl.fetch  = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                // A match wins over reaching the last entry.
                priority if (stat.match)
                begin
                    ctl.hit    = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stat.last)
                begin
                    ctl.miss   = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

`default_nettype wire

// File: rtl/core/bounded_deque_with_search_top.sv
// Top level of the bounded deque with search: controller and datapath.
// Add, remove, reverse and empty-list search: result in the cycle after the request.
// Search: S_FETCH primes the memory read, then S_SCAN checks one entry per cycle;
// the result is registered after the first match, or after the last entry on a miss.
// A new request is taken in the cycle its predecessor's result shows; the memory's
// single read port sets the scan rate. Reset clears count, head, direction and FSM.
`default_nettype none

module bounded_deque_with_search_top #(
    parameter int DEPTH = 16
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire bdq_pkg::req_t request,
    output logic          busy,
    output logic          done,
    output bdq_pkg::res_t result
);
    import bdq_pkg::*;

    ctl_t  ctl;
    stat_t stat;

    bdq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (request.cmd),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    bdq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .ctl     (ctl),
        .stat    (stat),
        .result  (result)
    );

endmodule

`default_nettype wire

// File: rtl/core/bdq_chk.sv
// Port-level checker for the bounded deque with search, bound to the top level.
`default_nettype none

module bdq_chk #(
    parameter int DEPTH = 16
) (
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     start,
    input wire bdq_pkg::req_t request,
    input wire logic     busy,
    input wire logic     done,
    input wire bdq_pkg::res_t result
);
    import bdq_pkg::*;

    localparam logic [4:0] FULL_FIELD = 5'(DEPTH);

    // A rejected add must report a full list.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_FULL)) |-> (result.count == FULL_FIELD))
        else $error("full status with count not at capacity");

    // An ignored remove must report an empty list.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_EMPTY)) |-> (result.count == 5'd0))
        else $error("empty status with nonzero count");

    // A hit cannot come with an error status.
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.found) |-> (result.status == ST_OK))
        else $error("found flag with error status");

    // Without a hit the index reads zero.
    a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.found) |-> (result.index == 4'd0))
        else $error("nonzero index without a match");

    // Every request other than a search, made while idle, answers in the next cycle.
    a_simple_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (request.cmd != CMD_SEARCH)) |=> done)
        else $error("single-cycle request gave no result");

endmodule

bind bounded_deque_with_search_top bdq_chk #(.DEPTH(DEPTH)) u_bdq_chk (.*);

`default_nettype wire
